@@ sv/sktbl_pkg.sv @@
package sktbl_pkg;

    // Fixed field widths
    localparam int KIND_W   = 2;
    localparam int KEY_W    = 64;
    localparam int IDENT_W  = 16;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 6;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;

    // Datapath operations issued by the controller
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NONE       = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD       = 4'd1;
    localparam logic [OP_W-1:0] OP_INS_INIT   = 4'd2;
    localparam logic [OP_W-1:0] OP_INS_SHIFT  = 4'd3;
    localparam logic [OP_W-1:0] OP_INS_PLACE  = 4'd4;
    localparam logic [OP_W-1:0] OP_SRCH_INIT  = 4'd5;
    localparam logic [OP_W-1:0] OP_SRCH_PROBE = 4'd6;
    localparam logic [OP_W-1:0] OP_SRCH_STEP  = 4'd7;
    localparam logic [OP_W-1:0] OP_CLEAR      = 4'd8;
    localparam logic [OP_W-1:0] OP_EMIT       = 4'd9;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [KEY_W-1:0]   key;
        logic [IDENT_W-1:0] ident;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDENT_W-1:0]  found_ident;
        logic [TOTAL_W-1:0]  entry_total;
    } result_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } dp_cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              full;
        logic              count_zero;
        logic              pos_one;
        logic              rd_gt;
        logic              search_live;
        logic              probe_eq;
        logic              out_free;
    } dp_stat_t;

endpackage

@@ sv/sktbl_dp.sv @@
module sktbl_dp #(
    parameter int TABLE_DEPTH = 32,
    parameter int KEY_BYTES   = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  sktbl_pkg::item_t   item,
    input  sktbl_pkg::dp_cmd_t cmd,
    output sktbl_pkg::dp_stat_t stat,
    input  logic               result_stall,
    output logic               result_valid,
    output sktbl_pkg::result_t result
);
    import sktbl_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    // Keep only the leading KEY_BYTES characters up to the first zero byte
    function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] res;
        logic             live;
        res  = '0;
        live = 1'b1;
        for (int b = 0; b < KEY_BYTES; b++) begin
            if (k[KEY_W-1-8*b -: 8] == 8'd0)
            begin
                live = 1'b0;
            end
            if (live)
            begin
                res[KEY_W-1-8*b -: 8] = k[KEY_W-1-8*b -: 8];
            end
        end
        return res;
    endfunction

    // Table storage
    logic [KEY_W-1:0]   key_mem   [TABLE_DEPTH];
    logic [IDENT_W-1:0] ident_mem [TABLE_DEPTH];
    logic [KEY_W-1:0]   rd_key_reg;
    logic [IDENT_W-1:0] rd_ident_reg;

    // Item and working registers
    logic [KIND_W-1:0]   kind_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [IDENT_W-1:0]  ident_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       pos_reg;
    logic signed [SW-1:0] lo_reg;
    logic signed [SW-1:0] hi_reg;
    logic [AW-1:0]       mid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [IDENT_W-1:0]  found_reg;
    result_t             result_reg;
    logic                result_valid_reg;

    logic [CW-1:0]        count_dec;
    logic [CW-1:0]        pos_dec2;
    logic [SW:0]          mid_sum;
    logic [SW-1:0]        mid_full;
    logic signed [SW-1:0] mid_ext;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [KEY_W-1:0]     wr_key;
    logic [IDENT_W-1:0]   wr_ident;
    logic [CW+TOTAL_W-1:0] total_ext;
    logic                 out_free;

    // Address arithmetic
    assign count_dec = count_reg - CW'(1);
    assign pos_dec2  = pos_reg - CW'(2);
    assign mid_sum   = {lo_reg[SW-1], lo_reg} + {hi_reg[SW-1], hi_reg};
    assign mid_full  = mid_sum[SW:1];
    assign mid_ext   = $signed({{(SW-AW){1'b0}}, mid_reg});

    // Read address select
    always_comb
    begin
        unique case (cmd.op)
            OP_INS_INIT:  rd_addr = count_dec[AW-1:0];
            OP_INS_SHIFT: rd_addr = pos_dec2[AW-1:0];
            default:      rd_addr = mid_full[AW-1:0];
        endcase
    end

    // Write port: shift an entry up, or place the new one
    assign wr_en    = (cmd.op == OP_INS_SHIFT) || (cmd.op == OP_INS_PLACE);
    assign wr_key   = (cmd.op == OP_INS_SHIFT) ? rd_key_reg : key_reg;
    assign wr_ident = (cmd.op == OP_INS_SHIFT) ? rd_ident_reg : ident_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[pos_reg[AW-1:0]]   <= wr_key;
            ident_mem[pos_reg[AW-1:0]] <= wr_ident;
        end
        rd_key_reg   <= key_mem[rd_addr];
        rd_ident_reg <= ident_mem[rd_addr];
    end

    // Entry count and output beat valid
    assign out_free = !result_valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == OP_CLEAR)
            begin
                count_reg <= '0;
            end
            else if (cmd.op == OP_INS_PLACE)
            begin
                count_reg <= count_reg + CW'(1);
            end

            if (cmd.op == OP_EMIT)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    assign total_ext = {{TOTAL_W{1'b0}}, count_reg};

    // Working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                kind_reg  <= item.kind;
                key_reg   <= norm_key(item.key);
                ident_reg <= item.ident;
                found_reg <= '0;
                if (item.kind == KIND_INSERT && count_reg == DEPTH_C)
                begin
                    status_reg <= ST_FULL;
                end
                else if (item.kind == KIND_SEARCH)
                begin
                    status_reg <= ST_MISSING;
                end
                else
                begin
                    status_reg <= ST_OK;
                end
            end
            OP_INS_INIT:
            begin
                pos_reg <= count_reg;
            end
            OP_INS_SHIFT:
            begin
                pos_reg <= pos_reg - CW'(1);
            end
            OP_SRCH_INIT:
            begin
                lo_reg <= '0;
                hi_reg <= $signed({1'b0, count_reg} - SW'(1));
            end
            OP_SRCH_PROBE:
            begin
                mid_reg <= mid_full[AW-1:0];
            end
            OP_SRCH_STEP:
            begin
                if (rd_key_reg == key_reg)
                begin
                    status_reg <= ST_OK;
                    found_reg  <= rd_ident_reg;
                end
                else if (rd_key_reg < key_reg)
                begin
                    lo_reg <= mid_ext + SW'(1);
                end
                else
                begin
                    hi_reg <= mid_ext - SW'(1);
                end
            end
            OP_EMIT:
            begin
                result_reg.status      <= status_reg;
                result_reg.found_ident <= found_reg;
                result_reg.entry_total <= total_ext[TOTAL_W-1:0];
            end
            default:
            begin
            end
        endcase
    end

    // Status toward the controller
    assign stat.kind        = kind_reg;
    assign stat.full        = (count_reg == DEPTH_C);
    assign stat.count_zero  = (count_reg == '0);
    assign stat.pos_one     = (pos_reg == CW'(1));
    assign stat.rd_gt       = (rd_key_reg > key_reg);
    assign stat.search_live = (lo_reg <= hi_reg);
    assign stat.probe_eq    = (rd_key_reg == key_reg);
    assign stat.out_free    = out_free;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

@@ sv/sktbl_ctrl.sv @@
module sktbl_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  sktbl_pkg::dp_stat_t stat,
    output sktbl_pkg::dp_cmd_t  cmd
);
    import sktbl_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_SHIFT    = 3'd2;
    localparam logic [2:0] S_PLACE    = 3'd3;
    localparam logic [2:0] S_PROBE    = 3'd4;
    localparam logic [2:0] S_CMP      = 3'd5;
    localparam logic [2:0] S_EMIT     = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign item_stall = (state_reg != S_IDLE);

    // Sequencing of one item
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.kind)
                    KIND_INSERT:
                    begin
                        if (stat.full)
                        begin
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            cmd.op     = OP_INS_INIT;
                            state_next = stat.count_zero ? S_PLACE : S_SHIFT;
                        end
                    end
                    KIND_SEARCH:
                    begin
                        cmd.op     = OP_SRCH_INIT;
                        state_next = S_PROBE;
                    end
                    KIND_CLEAR:
                    begin
                        cmd.op     = OP_CLEAR;
                        state_next = S_EMIT;
                    end
                    default:
                    begin
                        state_next = S_EMIT;
                    end
                endcase
            end
            S_SHIFT:
            begin
                // Move larger entries up until the slot is found
                if (stat.rd_gt)
                begin
                    cmd.op     = OP_INS_SHIFT;
                    state_next = stat.pos_one ? S_PLACE : S_SHIFT;
                end
                else
                begin
                    cmd.op     = OP_INS_PLACE;
                    state_next = S_EMIT;
                end
            end
            S_PLACE:
            begin
                cmd.op     = OP_INS_PLACE;
                state_next = S_EMIT;
            end
            S_PROBE:
            begin
                if (stat.search_live)
                begin
                    cmd.op     = OP_SRCH_PROBE;
                    state_next = S_CMP;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_CMP:
            begin
                cmd.op     = OP_SRCH_STEP;
                state_next = stat.probe_eq ? S_EMIT : S_PROBE;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ sv/sorted_key_table_search_core.sv @@
// Sorted key table: holds up to TABLE_DEPTH (name key, identifier) entries in
// ascending key order in a one-write, one-read table memory. An insert beat
// places the entry after all equal keys, a search beat does a binary search
// (mid rounded down), a clear beat empties the table; each input beat yields
// exactly one result beat. One item is worked at a time. An insert shifts
// larger entries up one entry per cycle through the memory port (a non-full
// table moves at most TABLE_DEPTH - 1 entries). A search makes at most
// ceil(log2(TABLE_DEPTH + 1)) probes; each probe is a memory read followed by
// a compare. Clear, an unused kind and a full insert go from dispatch straight
// to the result. The next item is accepted the cycle after the previous result
// is loaded into the output register; a stalled result beat only holds back
// the next result. Keys are normalized to the top KEY_BYTES characters up to
// the first zero byte; entry_total carries the low 6 bits of the count.
module sorted_key_table_search_core #(
    parameter int TABLE_DEPTH = 32,
    parameter int KEY_BYTES   = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  sktbl_pkg::item_t   item,
    output logic               result_valid,
    input  logic               result_stall,
    output sktbl_pkg::result_t result
);
    import sktbl_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    sktbl_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    sktbl_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BYTES   (KEY_BYTES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .stat         (stat),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
